### hdl/bxd_pkg.sv
package bxd_pkg;

  // Widths fixed by the register and pixel formats
  localparam int unsigned CfgW = 13;
  localparam int unsigned ChanW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DefMaxDimension = 4096;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegSourceWidth = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSourceHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaxEdge = 2'd2;

  typedef struct packed {
    logic [ChanW-1:0] in_red;
    logic [ChanW-1:0] in_green;
    logic [ChanW-1:0] in_blue;
    logic [ChanW-1:0] in_alpha;
  } pix_t;

  typedef struct packed {
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;
    logic [ChanW-1:0] out_alpha;
    logic             frame_end;
  } res_t;

  typedef enum logic [3:0] {
    ST_MUL,
    ST_LDW,
    ST_DIVW,
    ST_DIVH,
    ST_DIVX,
    ST_DIVY,
    ST_IDLE,
    ST_ACC,
    ST_MEAN,
    ST_EMIT
  } state_e;

endpackage

### hdl/box_area_average_downscaler_unit.sv
// Pass-through (no reduction): one beat per cycle unless the output stalls; result registered
// in the cycle after accept. Reduction: per source pixel a column-sum store read, then add and
// write back, before the next is taken; a pixel that closes a box adds bit-serial mean division
// (eight quotient bits) and an emit. After reset and after each write to a known register, setup
// runs products, a load, four serial divisions for output size and box steps; no pixel is taken.
// Reset (async, active low): width 1, height 1, max edge 0; position restarts at pixel (0,0).
module box_area_average_downscaler_unit #(
  parameter int unsigned MAX_DIMENSION = bxd_pkg::DefMaxDimension
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  bxd_pkg::pix_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output bxd_pkg::res_t                out_data_o,
  input  logic                         cfg_we_i,
  input  logic [bxd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bxd_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned DIM_W = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DIMENSION);
  localparam int unsigned CNT_W = 2 * DIM_W;
  localparam int unsigned NUM_W = 2 * DIM_W + 1;
  localparam int unsigned DEN_W = DIM_W + 1;
  localparam int unsigned SUM_W = bxd_pkg::ChanW + 2 * IDX_W;
  localparam int unsigned MW = CNT_W + bxd_pkg::ChanW;
  localparam int unsigned DCNT_W = $clog2(NUM_W + 1);
  localparam int unsigned CW = bxd_pkg::ChanW;

  // Configuration registers
  logic [bxd_pkg::CfgW-1:0] sw_cfg_q, sh_cfg_q, me_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_cfg_q <= bxd_pkg::CfgW'(1);
      sh_cfg_q <= bxd_pkg::CfgW'(1);
      me_cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bxd_pkg::RegSourceWidth:  sw_cfg_q <= cfg_data_i;
        bxd_pkg::RegSourceHeight: sh_cfg_q <= cfg_data_i;
        bxd_pkg::RegMaxEdge:      me_cfg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes and pick the mode
  logic [31:0]      sw_x, sh_x, me_x;
  logic [DIM_W-1:0] sw_c, sh_c, lg_c, me_t;
  logic             passthru;

  always_comb begin
    sw_x = 32'(sw_cfg_q);
    sh_x = 32'(sh_cfg_q);
    me_x = 32'(me_cfg_q);
    sw_c = (sw_x == 32'd0) ? DIM_W'(1) :
           (sw_x > 32'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : DIM_W'(sw_x);
    sh_c = (sh_x == 32'd0) ? DIM_W'(1) :
           (sh_x > 32'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : DIM_W'(sh_x);
    lg_c = (sw_c > sh_c) ? sw_c : sh_c;
    me_t = DIM_W'(me_cfg_q);
    passthru = (me_x == 32'd0) || (32'(lg_c) <= me_x);
  end

  // State and control
  bxd_pkg::state_e state_q, state_d;
  logic [DCNT_W-1:0] div_cnt_q;
  logic              div_done;
  logic [2:0]        bit_q;
  logic              last_q;
  logic              out_valid_q;
  logic              out_free;
  logic              cfg_hit;
  logic              in_acc, pt_acc, rd_acc, div_ld, emit, acc_wr;

  assign div_done = (div_cnt_q == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  // Only a write to a known register restarts setup and position
  assign cfg_hit = cfg_we_i && ((cfg_index_i == bxd_pkg::RegSourceWidth) ||
                                (cfg_index_i == bxd_pkg::RegSourceHeight) ||
                                (cfg_index_i == bxd_pkg::RegMaxEdge));

  always_comb begin
    state_d = state_q;
    case (state_q)
      bxd_pkg::ST_MUL:  state_d = bxd_pkg::ST_LDW;
      bxd_pkg::ST_LDW:  state_d = bxd_pkg::ST_DIVW;
      bxd_pkg::ST_DIVW: if (div_done) state_d = bxd_pkg::ST_DIVH;
      bxd_pkg::ST_DIVH: if (div_done) state_d = bxd_pkg::ST_DIVX;
      bxd_pkg::ST_DIVX: if (div_done) state_d = bxd_pkg::ST_DIVY;
      bxd_pkg::ST_DIVY: if (div_done) state_d = bxd_pkg::ST_IDLE;
      bxd_pkg::ST_IDLE: if (rd_acc) state_d = bxd_pkg::ST_ACC;
      bxd_pkg::ST_ACC:  state_d = last_q ? bxd_pkg::ST_MEAN : bxd_pkg::ST_IDLE;
      bxd_pkg::ST_MEAN: if (bit_q == 3'd0) state_d = bxd_pkg::ST_EMIT;
      bxd_pkg::ST_EMIT: if (out_free) state_d = bxd_pkg::ST_IDLE;
      default:          state_d = bxd_pkg::ST_MUL;
    endcase
    if (cfg_hit) state_d = bxd_pkg::ST_MUL;
  end

  always_comb begin
    in_stall_o = !((state_q == bxd_pkg::ST_IDLE) && (!passthru || out_free));
    in_acc = in_valid_i && !in_stall_o;
    pt_acc = in_acc && passthru;
    rd_acc = in_acc && !passthru;
    emit = (state_q == bxd_pkg::ST_EMIT) && out_free;
    acc_wr = (state_q == bxd_pkg::ST_ACC);
    div_ld = (state_q == bxd_pkg::ST_LDW) ||
             (div_done && ((state_q == bxd_pkg::ST_DIVW) ||
                           (state_q == bxd_pkg::ST_DIVH) ||
                           (state_q == bxd_pkg::ST_DIVX)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bxd_pkg::ST_MUL;
    else         state_q <= state_d;
  end

  // Setup products
  logic [CNT_W-1:0] prod_w_q, prod_h_q;

  always_ff @(posedge clk_i) begin
    if (state_q == bxd_pkg::ST_MUL) begin
      prod_w_q <= CNT_W'(sw_c) * CNT_W'(me_t);
      prod_h_q <= CNT_W'(sh_c) * CNT_W'(me_t);
    end
  end

  // Serial divider for setup, one quotient bit a cycle
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quo_q;
  logic [DEN_W-1:0] div_rem_q, div_den_q;
  logic [DEN_W:0]   rem_sh;
  logic             div_ge;
  logic [DIM_W-1:0] dw_q, dh_q, dw_d;

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (state_q)
      bxd_pkg::ST_LDW: begin
        div_num = {prod_w_q, 1'b0} + NUM_W'(lg_c);
        div_den = {lg_c, 1'b0};
      end
      bxd_pkg::ST_DIVW: begin
        div_num = {prod_h_q, 1'b0} + NUM_W'(lg_c);
        div_den = {lg_c, 1'b0};
      end
      bxd_pkg::ST_DIVH: begin
        div_num = NUM_W'(sw_c);
        div_den = DEN_W'(dw_q);
      end
      bxd_pkg::ST_DIVX: begin
        div_num = NUM_W'(sh_c);
        div_den = DEN_W'(dh_q);
      end
      default: ;
    endcase
    rem_sh = {div_rem_q, div_quo_q[NUM_W-1]};
    div_ge = rem_sh >= {1'b0, div_den_q};
    dw_d = (div_quo_q == '0) ? DIM_W'(1) : DIM_W'(div_quo_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_ld) begin
      div_cnt_q <= DCNT_W'(NUM_W);
    end else if (!div_done) begin
      div_cnt_q <= div_cnt_q - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ld) begin
      div_quo_q <= div_num;
      div_rem_q <= '0;
      div_den_q <= div_den;
    end else if (!div_done) begin
      div_quo_q <= {div_quo_q[NUM_W-2:0], div_ge};
      div_rem_q <= div_ge ? DEN_W'(rem_sh - {1'b0, div_den_q}) : DEN_W'(rem_sh);
    end
  end

  // Output size and box steps
  logic [DIM_W-1:0] xqs_q, xrs_q, yqs_q, yrs_q;

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      case (state_q)
        bxd_pkg::ST_DIVW: dw_q <= dw_d;
        bxd_pkg::ST_DIVH: dh_q <= dw_d;
        bxd_pkg::ST_DIVX: begin
          xqs_q <= DIM_W'(div_quo_q);
          xrs_q <= DIM_W'(div_rem_q);
        end
        bxd_pkg::ST_DIVY: begin
          yqs_q <= DIM_W'(div_quo_q);
          yrs_q <= DIM_W'(div_rem_q);
        end
        default: ;
      endcase
    end
  end

  // Position and box edges
  logic [DIM_W-1:0] sc_q, sr_q, x0_q, x1_q, xr_q, y0_q, y1_q, yr_q;
  logic [IDX_W-1:0] oc_q;
  logic [DIM_W-1:0] sc_inc, sr_inc, x1_nx, xr_nx, y1_nx, yr_nx;
  logic [DEN_W-1:0] xr_sum, yr_sum;
  logic             xr_wrap, yr_wrap, row_end, frm_end, xbox_end, ybox_end, setup_end;

  always_comb begin
    sc_inc = sc_q + DIM_W'(1);
    sr_inc = sr_q + DIM_W'(1);
    row_end = (sc_inc == sw_c);
    frm_end = (sr_inc == sh_c);
    xbox_end = (sc_inc == x1_q);
    ybox_end = (sr_inc == y1_q);
    xr_sum = DEN_W'(xr_q) + DEN_W'(xrs_q);
    xr_wrap = xr_sum >= DEN_W'(dw_q);
    xr_nx = xr_wrap ? DIM_W'(xr_sum - DEN_W'(dw_q)) : DIM_W'(xr_sum);
    x1_nx = x1_q + xqs_q + DIM_W'(xr_wrap);
    yr_sum = DEN_W'(yr_q) + DEN_W'(yrs_q);
    yr_wrap = yr_sum >= DEN_W'(dh_q);
    yr_nx = yr_wrap ? DIM_W'(yr_sum - DEN_W'(dh_q)) : DIM_W'(yr_sum);
    y1_nx = y1_q + yqs_q + DIM_W'(yr_wrap);
    setup_end = (state_q == bxd_pkg::ST_DIVY) && div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
      sr_q <= '0;
      oc_q <= '0;
      x0_q <= '0;
      x1_q <= '0;
      xr_q <= '0;
      y0_q <= '0;
      y1_q <= '0;
      yr_q <= '0;
    end else if (setup_end) begin
      // restart at pixel (0,0) with the first box
      sc_q <= '0;
      sr_q <= '0;
      oc_q <= '0;
      x0_q <= '0;
      x1_q <= xqs_q;
      xr_q <= xrs_q;
      y0_q <= '0;
      y1_q <= DIM_W'(div_quo_q);
      yr_q <= DIM_W'(div_rem_q);
    end else if (pt_acc) begin
      sc_q <= row_end ? '0 : sc_inc;
      if (row_end) sr_q <= frm_end ? '0 : sr_inc;
    end else if (rd_acc) begin
      if (row_end) begin
        sc_q <= '0;
        oc_q <= '0;
        x0_q <= '0;
        x1_q <= xqs_q;
        xr_q <= xrs_q;
        if (frm_end) begin
          sr_q <= '0;
          y0_q <= '0;
          y1_q <= yqs_q;
          yr_q <= yrs_q;
        end else begin
          sr_q <= sr_inc;
          if (ybox_end) begin
            y0_q <= y1_q;
            y1_q <= y1_nx;
            yr_q <= yr_nx;
          end
        end
      end else begin
        sc_q <= sc_inc;
        if (xbox_end) begin
          oc_q <= oc_q + IDX_W'(1);
          x0_q <= x1_q;
          x1_q <= x1_nx;
          xr_q <= xr_nx;
        end
      end
    end
  end

  // Latch the beat for the read-modify-write
  logic [3:0][CW-1:0] pix_q;
  logic               first_q, fe_q;
  logic [IDX_W-1:0]   wa_q;
  logic [CNT_W-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (rd_acc) begin
      pix_q <= {in_data_i.in_red, in_data_i.in_green, in_data_i.in_blue, in_data_i.in_alpha};
      first_q <= (sc_q == x0_q) && (sr_q == y0_q);
      fe_q <= (x1_q == sw_c) && (y1_q == sh_c);
      wa_q <= oc_q;
      cnt_q <= CNT_W'(x1_q - x0_q) * CNT_W'(y1_q - y0_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     last_q <= 1'b0;
    else if (rd_acc) last_q <= xbox_end && ybox_end;
  end

  // Column-sum store, one word holds four channel sums
  logic [3:0][SUM_W-1:0] sum_mem [MAX_DIMENSION];
  logic [3:0][SUM_W-1:0] rd_q, sum_nx;

  always_ff @(posedge clk_i) begin
    if (rd_acc) rd_q <= sum_mem[oc_q];
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_nx[k] = first_q ? SUM_W'(pix_q[k]) : rd_q[k] + SUM_W'(pix_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_wr) sum_mem[wa_q] <= sum_nx;
  end

  // Bit-serial mean, quotient is below 256
  logic [3:0][MW-1:0] mrem_q;
  logic [3:0][CW-1:0] mq_q;
  logic [MW-1:0]      dsh;

  assign dsh = MW'(cnt_q) << bit_q;

  always_ff @(posedge clk_i) begin
    if (acc_wr && last_q) begin
      for (int k = 0; k < 4; k++) begin
        mrem_q[k] <= MW'(sum_nx[k]);
        mq_q[k] <= '0;
      end
    end else if (state_q == bxd_pkg::ST_MEAN) begin
      for (int k = 0; k < 4; k++) begin
        if (mrem_q[k] >= dsh) begin
          mrem_q[k] <= mrem_q[k] - dsh;
          mq_q[k][bit_q] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (acc_wr) begin
      bit_q <= 3'd7;
    end else if (state_q == bxd_pkg::ST_MEAN) begin
      bit_q <= bit_q - 3'd1;
    end
  end

  // Output register
  bxd_pkg::res_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pt_acc || emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pt_acc) begin
      out_q.out_red <= in_data_i.in_red;
      out_q.out_green <= in_data_i.in_green;
      out_q.out_blue <= in_data_i.in_blue;
      out_q.out_alpha <= in_data_i.in_alpha;
      out_q.frame_end <= row_end && frm_end;
    end else if (emit) begin
      out_q.out_red <= mq_q[3];
      out_q.out_green <= mq_q[2];
      out_q.out_blue <= mq_q[1];
      out_q.out_alpha <= mq_q[0];
      out_q.frame_end <= fe_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

### tb/tb_box_area_average_downscaler_unit.sv
module tb_box_area_average_downscaler_unit;

  localparam int unsigned Dim = 4096;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned ItemTarget = 550;
  localparam longint unsigned CycleLimit = 2_000_000;
  // Index with no register behind it
  localparam logic [bxd_pkg::CfgIdxW-1:0] RegUnknown = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  bxd_pkg::pix_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  bxd_pkg::res_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [bxd_pkg::CfgIdxW-1:0] cfg_index_i = bxd_pkg::RegSourceWidth;
  logic [bxd_pkg::CfgW-1:0] cfg_data_i = '0;

  box_area_average_downscaler_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the scaler state
  int unsigned img_w, img_h, edge_max;
  int unsigned src_col, src_row, dst_col, dst_row;
  int unsigned sum_r[Dim], sum_g[Dim], sum_b[Dim], sum_a[Dim];
  bxd_pkg::res_t pending_px[$];

  int unsigned pixels_sent, pixels_out, mismatches, cfg_writes;
  bit sender_gaps, receiver_gaps, hold_off_req;
  longint unsigned cycle_cnt;

  function automatic int unsigned fit_size(int unsigned v);
    if (v < 1) return 1;
    if (v > Dim) return Dim;
    return v;
  endfunction

  function automatic int unsigned out_edge(int unsigned e, int unsigned lim, int unsigned lg);
    longint unsigned r;
    r = (2 * longint'(e) * lim + lg) / (2 * longint'(lg));
    return (r < 1) ? 1 : int'(r);
  endfunction

  function automatic void restart_frame();
    src_col = 0; src_row = 0; dst_col = 0; dst_row = 0;
  endfunction

  // Work out the box mean (or passed pixel) that one accepted beat produces
  function automatic void predict_box(bxd_pkg::pix_t p);
    int unsigned sw, sh, lg, dw, dh, oc, orw, x0, x1, y0, y1, cnt;
    bxd_pkg::res_t r;
    sw = fit_size(img_w);
    sh = fit_size(img_h);
    lg = (sw > sh) ? sw : sh;
    if (src_col >= sw || src_row >= sh) restart_frame();
    if (edge_max == 0 || lg <= edge_max) begin
      r = '{p.in_red, p.in_green, p.in_blue, p.in_alpha,
            (src_col == sw - 1 && src_row == sh - 1)};
      pending_px.push_back(r);
      src_col++;
      if (src_col >= sw) begin
        src_col = 0;
        src_row++;
        if (src_row >= sh) src_row = 0;
      end
      dst_col = src_col;
      dst_row = src_row;
      return;
    end
    dw = out_edge(sw, edge_max, lg);
    dh = out_edge(sh, edge_max, lg);
    oc = (dst_col < dw) ? dst_col : dw - 1;
    orw = (dst_row < dh) ? dst_row : dh - 1;
    x0 = oc * sw / dw;
    x1 = (oc + 1) * sw / dw;
    y0 = orw * sh / dh;
    y1 = (orw + 1) * sh / dh;
    if (src_col == x0 && src_row == y0) begin
      sum_r[oc] = p.in_red; sum_g[oc] = p.in_green;
      sum_b[oc] = p.in_blue; sum_a[oc] = p.in_alpha;
    end else begin
      sum_r[oc] += p.in_red; sum_g[oc] += p.in_green;
      sum_b[oc] += p.in_blue; sum_a[oc] += p.in_alpha;
    end
    if (src_col + 1 == x1 && src_row + 1 == y1) begin
      cnt = (x1 - x0) * (y1 - y0);
      if (cnt == 0) cnt = 1;
      r.out_red = 8'(sum_r[oc] / cnt);
      r.out_green = 8'(sum_g[oc] / cnt);
      r.out_blue = 8'(sum_b[oc] / cnt);
      r.out_alpha = 8'(sum_a[oc] / cnt);
      r.frame_end = (oc == dw - 1 && orw == dh - 1);
      pending_px.push_back(r);
    end
    src_col++;
    if (src_col >= x1) oc++;
    if (src_col >= sw) begin
      src_col = 0;
      oc = 0;
      src_row++;
      if (src_row >= y1) orw++;
      if (src_row >= sh) begin
        src_row = 0;
        orw = 0;
      end
    end
    dst_col = oc;
    dst_row = orw;
  endfunction

  // Offer one pixel, hold it until taken, then idle for a drawn gap
  task automatic send_pixel(bxd_pkg::pix_t p);
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    predict_box(p);
    pixels_sent++;
    gap = sender_gaps ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic bxd_pkg::pix_t any_pixel();
    return bxd_pkg::pix_t'($urandom);
  endfunction

  // Drain, let the block settle, then write one register
  task automatic write_reg(logic [bxd_pkg::CfgIdxW-1:0] idx, int unsigned val);
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= bxd_pkg::CfgW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    case (idx)
      bxd_pkg::RegSourceWidth: begin img_w = val & 13'h1fff; restart_frame(); end
      bxd_pkg::RegSourceHeight: begin img_h = val & 13'h1fff; restart_frame(); end
      bxd_pkg::RegMaxEdge: begin edge_max = val & 13'h1fff; restart_frame(); end
      default: ;
    endcase
  endtask

  task automatic set_geometry(int unsigned w, int unsigned h, int unsigned m);
    write_reg(bxd_pkg::RegSourceWidth, w);
    write_reg(bxd_pkg::RegSourceHeight, h);
    write_reg(bxd_pkg::RegMaxEdge, m);
  endtask

  task automatic send_frame();
    repeat (fit_size(img_w) * fit_size(img_h)) send_pixel(any_pixel());
  endtask

  // Reset defaults pass each pixel as a one-pixel frame
  task automatic test_passthrough_defaults();
    send_pixel('0);
    send_pixel('1);
    send_pixel(bxd_pkg::pix_t'(32'haa55_aa55));
    send_pixel(bxd_pkg::pix_t'(32'h55aa_55aa));
  endtask

  // Out-of-range sizes are clamped; unknown index is ignored
  task automatic test_size_clamp();
    set_geometry(0, 3, 0);
    send_frame();
    write_reg(bxd_pkg::RegSourceWidth, 8191);
    write_reg(bxd_pkg::RegMaxEdge, 4096);
    repeat (5) send_pixel(any_pixel());
    set_geometry(3, 2, 0);
    send_pixel(any_pixel());
    write_reg(RegUnknown, 1);
    repeat (5) send_pixel(any_pixel());
  endtask

  // Small reductions, including a one-pixel output
  task automatic test_reduction_directed();
    set_geometry(4, 4, 2);
    repeat (16) send_pixel('1);
    set_geometry(3, 1, 2);
    send_frame();
    set_geometry(5, 3, 1);
    send_frame();
  endtask

  // Long row of full-scale pixels squeezed into one output pixel
  task automatic test_widest_row();
    set_geometry(256, 1, 1);
    repeat (256) send_pixel('1);
  endtask

  // Random small frames, most complete, some abandoned part way
  task automatic test_random_frames();
    int unsigned n;
    while (pixels_sent < ItemTarget) begin
      sender_gaps = $urandom_range(0, 3) != 0;
      receiver_gaps = $urandom_range(0, 3) != 0;
      set_geometry($urandom_range(1, 12), $urandom_range(1, 12), $urandom_range(0, 12));
      n = fit_size(img_w) * fit_size(img_h);
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n);
      repeat (n) send_pixel(any_pixel());
    end
  endtask

  // Receiver holds off while the sender keeps offering pixels
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    set_geometry(6, 6, 0);
    hold_off_req = 1'b1;
    send_frame();
    set_geometry(8, 6, 3);
    hold_off_req = 1'b1;
    send_frame();
    sender_gaps = 1'b1;
  endtask

  // Receiver stall pattern, with a long hold-off on request
  initial begin
    int unsigned n;
    forever begin
      if (hold_off_req) n = 300;
      else n = receiver_gaps ? $urandom_range(0, 16) : 0;
      hold_off_req = 1'b0;
      if (n != 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  // Compare each output beat with the oldest expected pixel
  always @(posedge clk_i) begin
    bxd_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pixels_out++;
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data_o);
      end else begin
        want = pending_px.pop_front();
        if (want.out_red !== out_data_o.out_red || want.out_green !== out_data_o.out_green ||
            want.out_blue !== out_data_o.out_blue ||
            want.out_alpha !== out_data_o.out_alpha ||
            want.frame_end !== out_data_o.frame_end) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("tb_box_area_average_downscaler_unit: done, errors");
      $finish;
    end
  end

  initial begin
    img_w = 1; img_h = 1; edge_max = 0;
    restart_frame();
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    hold_off_req = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough_defaults();
    test_size_clamp();
    test_reduction_directed();
    test_widest_row();
    test_backpressure();
    test_random_frames();
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    mismatches += pending_px.size();
    $display("sent %0d pixels, checked %0d output pixels, %0d register writes",
             pixels_sent, pixels_out, cfg_writes);
    $display("covered pass-through, clamped sizes, a long row and random reductions");
    if (mismatches == 0) begin
      $display("tb_box_area_average_downscaler_unit: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_box_area_average_downscaler_unit: done, errors");
    end
    $finish;
  end

endmodule
